>>> rtl/core/color_escape_run_splitter_core_assert.svh
// Assertion macros used by the checker file of the color escape run splitter.
`ifndef COLOR_ESCAPE_RUN_SPLITTER_CORE_ASSERT_SVH
`define COLOR_ESCAPE_RUN_SPLITTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CERS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cers assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CERS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cers assertion failed in the next cycle");

`endif

>>> rtl/core/cers_pkg.sv
// ----------------------------------------------------------------------------
// cers_pkg
// Constants and helpers for the color escape run splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cers_pkg;

	// Characters that drive the escape parser.
	localparam logic [7:0] CH_PIPE    = 8'h7C;
	localparam logic [7:0] CH_LOWER_C = 8'h63;
	localparam logic [7:0] CH_UPPER_C = 8'h43;
	localparam logic [7:0] CH_LOWER_R = 8'h72;
	localparam logic [7:0] CH_UPPER_R = 8'h52;

	// Escape phases: idle, after the bar, then after the letter and k digits.
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_BAR  = 4'd1;
	localparam logic [3:0] PH_DIG0 = 4'd2;
	localparam logic [3:0] PH_LAST = 4'd9;

	// Most result beats that one text byte can cause.
	localparam int MAX_RESULTS = 10;
	localparam int HELD_DEPTH  = 8;

	// Hex digit decode: bit 4 is set when the byte is a hex digit.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/color_escape_run_splitter_core.sv
// ----------------------------------------------------------------------------
// color_escape_run_splitter_core
// Strips color escapes from a byte stream and tags each text byte with its
// color, a default flag and a run start flag.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   text_byte, end_of_text
// cfg       input      cfg_valid / cfg_ready cfg_data (default color)
// out       output     out_valid / out_ready out_byte, byte_valid, color_rgba,
//                                            from_default, starts_run,
//                                            last_result
//
// The parser updates its state in the cycle a beat is accepted and loads the
// result beats of that byte into a burst register; they reach the output
// register one per cycle while out_ready is high. A byte with one result
// sustains one beat per cycle while out_ready is high. A failed escape holds
// in_ready low while its held bytes drain. Reset restores the default color
// to all ones; there is no clearing pass. The cfg channel is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_escape_run_splitter_core
	import cers_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic [31:0] color_rgba,
	output logic        from_default,
	output logic        starts_run,
	output logic        last_result
);

	localparam int CW = $clog2(MAX_RESULTS + 1);

	// Parser state.
	logic [3:0]  phase_q;
	logic [31:0] acc_q;
	logic [31:0] default_q;
	logic [31:0] color_q;
	logic        inh_q;
	logic        pend_q;
	logic [7:0]  held_q [HELD_DEPTH];

	// Burst register with the pending result beats of one byte.
	logic [7:0]    bytes_s1 [MAX_RESULTS];
	logic [CW-1:0] cnt_s1;
	logic          valid_s1;
	logic          first_s1;
	logic          last_s1;
	logic [31:0]   color_s1;
	logic          inh_s1;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q;
	logic [31:0] color_out_q;
	logic        from_default_q;
	logic        starts_run_q;
	logic        last_result_q;

	// Parser decode.
	logic        is_pipe, is_c, is_r, hex_ok, fail, success, held_wr, eb, bare, load;
	logic [3:0]  hex_d;
	logic [4:0]  hex_r;
	logic [3:0]  nphase, m;
	logic [31:0] nacc, ncolor, argb;
	logic        ninh;
	logic [CW-1:0] cnt;
	logic [7:0]  pre [MAX_RESULTS];
	logic [7:0]  build [MAX_RESULTS];
	logic        accept, move;

	assign accept = in_valid & in_ready;
	assign move   = (cnt_s1 != '0) & (~out_valid_q | out_ready);
	assign in_ready  = (cnt_s1 == '0) | (move & (cnt_s1 == CW'(1)));
	assign cfg_ready = 1'b1;

	// Next parser state and the shape of this byte's result list.
	always_comb begin
		hex_r   = hex_decode(text_byte);
		hex_ok  = hex_r[4];
		hex_d   = hex_r[3:0];
		is_pipe = (text_byte == CH_PIPE);
		is_c    = (text_byte == CH_LOWER_C) | (text_byte == CH_UPPER_C);
		is_r    = (text_byte == CH_LOWER_R) | (text_byte == CH_UPPER_R);
		argb    = {acc_q[27:0], hex_d};
		nphase  = phase_q;
		nacc    = acc_q;
		ncolor  = color_q;
		ninh    = inh_q;
		success = 1'b0;
		fail    = 1'b0;
		held_wr = 1'b0;
		if (phase_q == PH_IDLE) begin
			nphase = is_pipe ? PH_BAR : PH_IDLE;
		end else if (phase_q == PH_BAR) begin
			if (is_c) begin
				nphase  = PH_DIG0;
				held_wr = 1'b1;
				nacc    = 32'd0;
			end else if (is_r) begin
				ncolor  = default_q;
				ninh    = 1'b1;
				success = 1'b1;
				nphase  = PH_IDLE;
			end else begin
				fail = 1'b1;
			end
		end else if (!hex_ok) begin
			fail = 1'b1;
		end else if (phase_q >= PH_LAST) begin
			ncolor  = {argb[23:0], argb[31:24]};
			ninh    = 1'b0;
			success = 1'b1;
			nacc    = 32'd0;
			nphase  = PH_IDLE;
		end else begin
			held_wr = 1'b1;
			nacc    = argb;
			nphase  = phase_q + 4'd1;
		end

		// Held bytes come first, then the current byte if it is emitted.
		if (fail) begin
			nphase = is_pipe ? PH_BAR : PH_IDLE;
			m      = phase_q;
			eb     = ~is_pipe | end_of_text;
		end else if (end_of_text && nphase != PH_IDLE) begin
			m  = nphase - 4'd1;
			eb = 1'b1;
		end else if (phase_q == PH_IDLE && !is_pipe) begin
			m  = 4'd0;
			eb = 1'b1;
		end else begin
			m  = 4'd0;
			eb = 1'b0;
		end
		cnt  = CW'(m) + CW'(eb);
		bare = end_of_text & (cnt == '0);
		load = accept & ((cnt != '0) | bare);
	end

	// Lay out the result bytes: bar, held letter and digits, current byte.
	always_comb begin
		pre[0] = CH_PIPE;
		for (int i = 0; i < HELD_DEPTH; i++) begin
			pre[i + 1] = held_q[i];
		end
		pre[MAX_RESULTS - 1] = 8'h00;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (4'(i) < m) begin
				build[i] = pre[i];
			end else if (4'(i) == m && eb) begin
				build[i] = text_byte;
			end else begin
				build[i] = 8'h00;
			end
		end
	end

	// Parser state registers and the default color register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			acc_q     <= 32'd0;
			default_q <= 32'hFFFF_FFFF;
			color_q   <= 32'hFFFF_FFFF;
			inh_q     <= 1'b1;
			pend_q    <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				default_q <= cfg_data;
				if (inh_q && !accept) begin
					color_q <= cfg_data;
				end
			end
			if (accept) begin
				if (end_of_text) begin
					phase_q <= PH_IDLE;
					acc_q   <= 32'd0;
					color_q <= default_q;
					inh_q   <= 1'b1;
					pend_q  <= 1'b1;
				end else begin
					phase_q <= nphase;
					acc_q   <= nacc;
					color_q <= ncolor;
					inh_q   <= ninh;
					if (success) begin
						pend_q <= 1'b1;
					end else if (cnt != '0) begin
						pend_q <= 1'b0;
					end
				end
			end
		end
	end

	// Held escape letter and digits; entries are read only after being written.
	always_ff @(posedge clk) begin
		if (accept && held_wr) begin
			held_q[3'(phase_q - 4'd1)] <= text_byte;
		end
	end

	// Burst register: load a new byte's results or shift one out per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (load) begin
			cnt_s1 <= bare ? CW'(1) : cnt;
		end else if (move) begin
			cnt_s1 <= cnt_s1 - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s1 <= build;
			valid_s1 <= ~bare;
			first_s1 <= pend_q & ~bare;
			last_s1  <= end_of_text;
			color_s1 <= ncolor;
			inh_s1   <= ninh;
		end else if (move) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				bytes_s1[i] <= bytes_s1[i + 1];
			end
			bytes_s1[MAX_RESULTS - 1] <= 8'h00;
			first_s1 <= 1'b0;
		end
	end

	// Output register holds one result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q     <= bytes_s1[0];
			byte_valid_q   <= valid_s1;
			color_out_q    <= color_s1;
			from_default_q <= inh_s1;
			starts_run_q   <= first_s1;
			last_result_q  <= last_s1 & (cnt_s1 == CW'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_valid   = byte_valid_q;
	assign color_rgba   = color_out_q;
	assign from_default = from_default_q;
	assign starts_run   = starts_run_q;
	assign last_result  = last_result_q;

endmodule

>>> rtl/core/cers_checker.sv
// ----------------------------------------------------------------------------
// cers_checker
// Port level checks for the color escape run splitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "color_escape_run_splitter_core_assert.svh"

module cers_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        starts_run,
	input logic        last_result
);

	// A stalled result beat stays offered and unchanged.
	`CERS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_result))

	// The bare end marker is always the last beat of a text and starts no run.
	`CERS_ASSERT_NOW(a_bare_marker, clk, arst_n, out_valid && !byte_valid, last_result && !starts_run && out_byte == 8'h00)

	// Input is held off only while results are queued, so output follows.
	`CERS_ASSERT_NEXT(a_stall_has_output, clk, arst_n, !in_ready, out_valid)

	// The configuration channel never back-pressures.
	`CERS_ASSERT_NOW(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)

endmodule

bind color_escape_run_splitter_core cers_checker u_cers_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.cfg_ready   (cfg_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.byte_valid  (byte_valid),
	.starts_run  (starts_run),
	.last_result (last_result)
);

>>> tb/tb_color_escape_run_splitter_core.sv
// ----------------------------------------------------------------------------
// tb_color_escape_run_splitter_core
// Self-checking bench for the color escape run splitter. Text bytes are
// driven through the valid/ready input channel while a local model of the
// escape parser predicts every output beat. Each output beat is checked field
// by field against the oldest prediction. The run covers directed escapes,
// random text with well-formed and broken escapes, several default colors,
// random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_color_escape_run_splitter_core;
	import cers_pkg::*;

	localparam int IDLE_PCT     = 27;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	// One input beat and one output beat as the bench sees them.
	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic        has_byte;
		logic [31:0] rgba;
		logic        dflt;
		logic        run_start;
		logic        is_last;
	} color_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_text = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'h0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic [31:0] color_rgba;
	logic        from_default;
	logic        starts_run;
	logic        last_result;

	// Stimulus and expectation stores.
	text_item_t  pending_q[$];
	logic [7:0]  text_q[$];
	color_beat_t exp_beats[$];
	int          items_queued = 0;
	int          fail_cnt = 0;
	int          cycle_cnt = 0;
	logic        in_taken = 1'b0;
	logic        cfg_taken = 1'b0;
	bit          snd_quiet = 1'b0;
	bit          rcv_quiet = 1'b0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	// Parser state of the prediction.
	logic [3:0]  esc_phase = PH_IDLE;
	logic [7:0]  held_chars [0:HELD_DEPTH-1];
	logic [31:0] digit_acc = 32'h0;
	logic [31:0] color_now = 32'hFFFF_FFFF;
	logic [31:0] dflt_color = 32'hFFFF_FFFF;
	bit          dflt_inherit = 1'b1;
	bit          run_pending = 1'b1;

	color_escape_run_splitter_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.color_rgba  (color_rgba),
		.from_default(from_default),
		.starts_run  (starts_run),
		.last_result (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction of the escape parser
	// ------------------------------------------------------------------

	function automatic int digit_value(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b) - int'("0");
		if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
		if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
		return -1;
	endfunction

	// A visible byte carries the current color and clears the run break.
	task automatic emit_text(input logic [7:0] b);
		color_beat_t nb;
		nb = '{ch: b, has_byte: 1'b1, rgba: color_now, dflt: dflt_inherit,
			run_start: run_pending, is_last: 1'b0};
		exp_beats.insert(exp_beats.size(), nb);
		run_pending = 1'b0;
	endtask

	// A pending escape turns back into literal text.
	task automatic release_held();
		int i;
		if (esc_phase != PH_IDLE) begin
			emit_text(CH_PIPE);
			if (esc_phase >= PH_DIG0) begin
				for (i = 0; i <= int'(esc_phase - PH_DIG0); i++)
					emit_text(held_chars[i]);
			end
			esc_phase = PH_IDLE;
		end
	endtask

	task automatic predict_item(input logic [7:0] b, input logic eot);
		int          n0;
		int          d;
		bit          again;
		logic [31:0] argb;
		color_beat_t tail;
		n0 = exp_beats.size();
		again = 1'b1;
		// A byte that breaks an escape is parsed once more from idle.
		while (again) begin
			again = 1'b0;
			if (esc_phase == PH_IDLE) begin
				if (b == CH_PIPE) esc_phase = PH_BAR;
				else emit_text(b);
			end else if (esc_phase == PH_BAR) begin
				if (b == CH_LOWER_C || b == CH_UPPER_C) begin
					held_chars[0] = b;
					digit_acc = 32'h0;
					esc_phase = PH_DIG0;
				end else if (b == CH_LOWER_R || b == CH_UPPER_R) begin
					color_now = dflt_color;
					dflt_inherit = 1'b1;
					run_pending = 1'b1;
					esc_phase = PH_IDLE;
				end else begin
					release_held();
					again = 1'b1;
				end
			end else begin
				d = digit_value(b);
				if (d < 0) begin
					release_held();
					again = 1'b1;
				end else if (esc_phase == PH_LAST) begin
					// Eight digits read as ARGB, stored as RGBA.
					argb = {digit_acc[27:0], 4'(d)};
					color_now = {argb[23:0], argb[31:24]};
					dflt_inherit = 1'b0;
					run_pending = 1'b1;
					digit_acc = 32'h0;
					esc_phase = PH_IDLE;
				end else begin
					held_chars[esc_phase - 4'd1] = b;
					digit_acc = {digit_acc[27:0], 4'(d)};
					esc_phase = esc_phase + 4'd1;
				end
			end
		end
		// End of text flushes, marks the last beat and restarts the parser.
		if (eot) begin
			release_held();
			if (exp_beats.size() == n0) begin
				tail = '{ch: 8'h00, has_byte: 1'b0, rgba: color_now, dflt: dflt_inherit,
					run_start: 1'b0, is_last: 1'b1};
			end else begin
				tail = exp_beats.pop_back();
				tail.is_last = 1'b1;
			end
			exp_beats.insert(exp_beats.size(), tail);
			esc_phase = PH_IDLE;
			digit_acc = 32'h0;
			color_now = dflt_color;
			dflt_inherit = 1'b1;
			run_pending = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Input driver, output receiver, monitor and watchdog
	// ------------------------------------------------------------------

	// The next beat is offered once the previous one has been taken.
	always @(negedge clk) begin
		text_item_t nxt;
		if (!in_valid || in_taken) begin
			if (arst_n && pending_q.size() != 0 &&
					(snd_quiet || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = pending_q.pop_front();
				text_byte <= nxt.ch;
				end_of_text <= nxt.eot;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random, or for a long stretch on request.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= rcv_quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Accepted inputs feed the prediction; accepted results are checked.
	always @(posedge clk) begin
		color_beat_t want;
		in_taken <= in_valid && in_ready;
		cfg_taken <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				dflt_color = cfg_data;
				if (dflt_inherit) color_now = cfg_data;
			end
			if (in_valid && in_ready) predict_item(text_byte, end_of_text);
			if (out_valid && out_ready) begin
				if (exp_beats.size() == 0) begin
					$display("%0t: result beat with none expected: out_byte %h color %h",
						$time, out_byte, color_rgba);
					fail_cnt++;
				end else begin
					want = exp_beats.pop_front();
					if (out_byte !== want.ch) begin
						$display("%0t: out_byte expected %h actual %h",
							$time, want.ch, out_byte);
						fail_cnt++;
					end
					if (byte_valid !== want.has_byte) begin
						$display("%0t: byte_valid expected %b actual %b",
							$time, want.has_byte, byte_valid);
						fail_cnt++;
					end
					if (color_rgba !== want.rgba) begin
						$display("%0t: color_rgba expected %h actual %h",
							$time, want.rgba, color_rgba);
						fail_cnt++;
					end
					if (from_default !== want.dflt) begin
						$display("%0t: from_default expected %b actual %b",
							$time, want.dflt, from_default);
						fail_cnt++;
					end
					if (starts_run !== want.run_start) begin
						$display("%0t: starts_run expected %b actual %b",
							$time, want.run_start, starts_run);
						fail_cnt++;
					end
					if (last_result !== want.is_last) begin
						$display("%0t: last_result expected %b actual %b",
							$time, want.is_last, last_result);
						fail_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results still expected", $time, exp_beats.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic logic [7:0] hex_char(input int v);
		if (v < 10) return 8'(int'("0") + v);
		if ($urandom_range(1) != 0) return 8'(int'("A") + v - 10);
		return 8'(int'("a") + v - 10);
	endfunction

	task automatic add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	task automatic add_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
	endtask

	// Moves the text built so far to the driver, closing it if asked.
	task automatic flush_text(input bit eot);
		text_item_t it;
		if (eot && text_q.size() == 0) text_q.insert(0, 8'($urandom_range(255)));
		while (text_q.size() != 0) begin
			it.ch = text_q.pop_front();
			it.eot = eot && (text_q.size() == 0);
			pending_q.insert(pending_q.size(), it);
			items_queued++;
		end
	endtask

	task automatic add_random_chunk();
		int sel;
		sel = $urandom_range(99);
		if (sel < 35) begin
			add_byte(CH_PIPE);
			add_byte(($urandom_range(1) != 0) ? CH_UPPER_C : CH_LOWER_C);
			repeat (8) add_byte(hex_char($urandom_range(15)));
		end else if (sel < 47) begin
			add_byte(CH_PIPE);
			add_byte(($urandom_range(1) != 0) ? CH_UPPER_R : CH_LOWER_R);
		end else if (sel < 60) begin
			// Color escape with up to seven digits, then a random byte.
			add_byte(CH_PIPE);
			add_byte(($urandom_range(1) != 0) ? CH_UPPER_C : CH_LOWER_C);
			repeat ($urandom_range(7)) add_byte(hex_char($urandom_range(15)));
			add_byte(8'($urandom_range(255)));
		end else if (sel < 66) begin
			add_byte(CH_PIPE);
			add_byte(8'($urandom_range(255)));
		end else if (sel < 72) begin
			// Escape left pending at the end of the text.
			add_byte(CH_PIPE);
			if ($urandom_range(1) != 0) begin
				add_byte(($urandom_range(1) != 0) ? CH_UPPER_C : CH_LOWER_C);
				repeat ($urandom_range(7)) add_byte(hex_char($urandom_range(15)));
			end
			flush_text(1'b1);
		end else begin
			repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random_texts(input int n, input bit close_last);
		int start;
		start = items_queued;
		while (items_queued + text_q.size() - start < n) begin
			add_random_chunk();
			if ($urandom_range(99) < 15) flush_text(1'b1);
		end
		flush_text(close_last);
	endtask

	// Waits until every expected beat has come and the parser has settled.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_q.size() != 0 || in_valid || exp_beats.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_default(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed texts with the reset default color.
		add_str("|caB09fF12");
		add_byte(8'hFF);
		flush_text(1'b1);
		add_str("|R");
		flush_text(1'b1);
		add_str("|x|r");
		add_byte(8'h00);
		flush_text(1'b1);
		add_str("|C1234567g");
		flush_text(1'b1);
		add_str("|");
		flush_text(1'b1);
		wait_drained();

		// Random texts under several default colors; an open text may
		// carry over a register write.
		write_default(32'h0000_0000);
		run_random_texts(70, $urandom_range(1) != 0);
		wait_drained();

		write_default(32'hFFFF_FFFF);
		snd_quiet = 1'b1;
		rcv_quiet = 1'b1;
		run_random_texts(70, $urandom_range(1) != 0);
		wait_drained();
		snd_quiet = 1'b0;
		rcv_quiet = 1'b0;

		// Long output stall while the sender keeps offering beats.
		write_default($urandom());
		hold_req++;
		run_random_texts(80, 1'b0);
		wait_drained();

		write_default($urandom());
		run_random_texts(80, $urandom_range(1) != 0);
		wait_drained();

		write_default(32'h8000_0001);
		run_random_texts(80, 1'b1);
		wait_drained();

		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/cers_pkg.sv
rtl/core/color_escape_run_splitter_core.sv
rtl/core/cers_checker.sv
tb/tb_color_escape_run_splitter_core.sv
